// ----- sv/bdeq_pkg.sv -----
// Shared types and codes for the bounded double-ended queue.
package bdeq_pkg;

   localparam int VALUE_W = 32;
   localparam int CMD_W   = 3;
   localparam int STAT_W  = 2;
   localparam int OCC_W   = 5;

   typedef logic [CMD_W-1:0]  cmd_type;
   typedef logic [STAT_W-1:0] stat_type;

   localparam cmd_type CMD_PUSH_FRONT = 3'd0;
   localparam cmd_type CMD_PUSH_BACK  = 3'd1;
   localparam cmd_type CMD_POP_FRONT  = 3'd2;
   localparam cmd_type CMD_POP_BACK   = 3'd3;
   localparam cmd_type CMD_DUMP       = 3'd4;

   localparam stat_type STAT_OK    = 2'd0;
   localparam stat_type STAT_EMPTY = 2'd1;
   localparam stat_type STAT_FULL  = 2'd2;

   // one result beat as it leaves the control logic
   typedef struct packed {
      logic signed [VALUE_W-1:0] entry_value;
      stat_type                  status;
      logic                      last;
      logic [OCC_W-1:0]          occupancy;
   } result_type;

endpackage

// ----- sv/bdeq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
module bdeq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/bdeq_ctrl.sv -----
// Ring pointers, entry count, command decode and dump walk over the entry RAM.
module bdeq_ctrl #(
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  bdeq_pkg::cmd_type                req_command,
   input  logic signed [bdeq_pkg::VALUE_W-1:0] req_value,
   input  logic                             res_room,
   output logic                             res_push,
   output bdeq_pkg::result_type             res
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_DUMP = 1'b1;

   logic          state_ff, state_in;
   logic [IW-1:0] front_ff, front_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] pos_ff, pos_in;
   logic [CW-1:0] left_ff, left_in;

   logic                            wr_en, rd_en;
   logic [IW-1:0]                   wr_addr, rd_addr;
   logic [bdeq_pkg::VALUE_W-1:0]    rd_data;
   logic                            accept, full, empty;
   logic [CW:0]                     back_sum;
   logic [IW-1:0]                   back_addr;

   function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] p);
      return (p == IW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [IW-1:0] ring_dec(input logic [IW-1:0] p);
      return (p == '0) ? IW'(DEPTH - 1) : p - 1'b1;
   endfunction

   bdeq_ram #(
      .WIDTH (bdeq_pkg::VALUE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign req_ready = (state_ff == S_IDLE) && res_room;
   assign accept    = req_valid && req_ready;

   // back slot: front + count stays below twice the depth, one wrap at most
   assign back_sum  = (CW+1)'(front_ff) + (CW+1)'(count_ff);
   assign back_addr = (back_sum >= (CW+1)'(DEPTH)) ? IW'(back_sum - (CW+1)'(DEPTH))
                                                   : IW'(back_sum);

   always_comb begin
      state_in = state_ff;
      front_in = front_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      left_in  = left_ff;
      wr_en    = 1'b0;
      wr_addr  = back_addr;
      rd_en    = 1'b0;
      rd_addr  = pos_ff;
      res_push = 1'b0;
      res.entry_value = '0;
      res.status      = bdeq_pkg::STAT_OK;
      res.last        = 1'b1;
      res.occupancy   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_push = 1'b1;
               unique case (req_command)
                  bdeq_pkg::CMD_PUSH_FRONT: begin
                     if (full) begin
                        res.status = bdeq_pkg::STAT_FULL;
                     end else begin
                        front_in = ring_dec(front_ff);
                        wr_en    = 1'b1;
                        wr_addr  = ring_dec(front_ff);
                        count_in = count_ff + 1'b1;
                     end
                  end
                  bdeq_pkg::CMD_PUSH_BACK: begin
                     if (full) begin
                        res.status = bdeq_pkg::STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  bdeq_pkg::CMD_POP_FRONT: begin
                     if (empty) begin
                        res.status = bdeq_pkg::STAT_EMPTY;
                     end else begin
                        front_in = ring_inc(front_ff);
                        count_in = count_ff - 1'b1;
                     end
                  end
                  bdeq_pkg::CMD_POP_BACK: begin
                     if (empty) begin
                        res.status = bdeq_pkg::STAT_EMPTY;
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                  end
                  bdeq_pkg::CMD_DUMP: begin
                     if (empty) begin
                        res.status = bdeq_pkg::STAT_EMPTY;
                     end else begin
                        // first read now, beats follow from the RAM register
                        res_push = 1'b0;
                        rd_en    = 1'b1;
                        rd_addr  = front_ff;
                        pos_in   = ring_inc(front_ff);
                        left_in  = count_ff - 1'b1;
                        state_in = S_DUMP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DUMP: begin
            // RAM output always holds the next entry here; advance only on room
            if (res_room) begin
               res_push        = 1'b1;
               res.entry_value = rd_data;
               res.last        = (left_ff == '0);
               if (left_ff != '0) begin
                  rd_en   = 1'b1;
                  rd_addr = pos_ff;
                  pos_in  = ring_inc(pos_ff);
                  left_in = left_ff - 1'b1;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      res.occupancy = bdeq_pkg::OCC_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         count_ff <= count_in;
      end
      pos_ff  <= pos_in;
      left_ff <= left_in;
   end

endmodule

// ----- sv/bounded_double_ended_queue.sv -----
// Top level of the bounded double-ended queue: control, entry RAM and result buffer.
//
//   channel | dir | ports                       | contents
//   --------+-----+-----------------------------+-------------------------------------
//   req     | in  | tvalid tready tdata tuser   | tdata: value; tuser: command
//   rsp     | out | tvalid tready tdata tuser   | tdata: entry_value, occupancy;
//           |     | tlast                       | tuser: status; tlast: final beat
//
// Push and pop each make one RAM write or none, plus the pointer update.
// A dump of N entries issues the first read, then one beat a cycle while the result
// buffer has room, as the RAM read port walks the ring; an empty dump gives one beat.
// Reset clears the front pointer, entry count and result buffer; RAM contents are
// left as they are, since only entries inside the count are ever read.
// A two-beat result buffer lets one more item in while a result waits; a stalled
// rsp side holds the dump walk in place and blocks new items once the buffer fills.
module bounded_double_ended_queue #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [2:0]  req_tuser,   // [2:0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] entry_value, [36:32] occupancy, [39:37] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast
);

   localparam logic [1:0] BUF_EMPTY = 2'd0;
   localparam logic [1:0] BUF_ONE   = 2'd1;
   localparam logic [1:0] BUF_FULL  = 2'd2;

   logic                 res_push, buf_room, rsp_pop;
   bdeq_pkg::result_type res;

   bdeq_pkg::result_type slot0_ff, slot0_in;
   bdeq_pkg::result_type slot1_ff, slot1_in;
   logic [1:0]           buf_cnt_ff, buf_cnt_in;

   bdeq_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_command (req_tuser),
      .req_value   (req_tdata),
      .res_room    (buf_room),
      .res_push    (res_push),
      .res         (res)
   );

   // result buffer: slot0 is the head shown on rsp, slot1 the skid beat
   assign rsp_pop  = rsp_tvalid && rsp_tready;
   assign buf_room = (buf_cnt_ff != BUF_FULL) || rsp_pop;

   always_comb begin
      slot0_in   = slot0_ff;
      slot1_in   = slot1_ff;
      buf_cnt_in = buf_cnt_ff;
      if (rsp_pop && res_push) begin
         if (buf_cnt_ff == BUF_FULL) begin
            slot0_in = slot1_ff;
            slot1_in = res;
         end else begin
            slot0_in = res;
         end
      end else if (rsp_pop) begin
         slot0_in   = slot1_ff;
         buf_cnt_in = buf_cnt_ff - 1'b1;
      end else if (res_push) begin
         if (buf_cnt_ff == BUF_EMPTY) begin
            slot0_in = res;
         end else begin
            slot1_in = res;
         end
         buf_cnt_in = buf_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_cnt_ff <= BUF_EMPTY;
      end else begin
         buf_cnt_ff <= buf_cnt_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_tvalid = (buf_cnt_ff != BUF_EMPTY);
   assign rsp_tdata  = {3'b000, slot0_ff.occupancy, slot0_ff.entry_value};
   assign rsp_tuser  = slot0_ff.status;
   assign rsp_tlast  = slot0_ff.last;

`ifndef NO_ASSERTIONS
   // the buffer never holds more than two beats
   a_buf_bound: assert property (@(posedge clock) disable iff (reset)
      (buf_cnt_ff == BUF_EMPTY) || (buf_cnt_ff == BUF_ONE) || (buf_cnt_ff == BUF_FULL))
      else $error("result buffer count out of range");

   // control only hands over a beat when the buffer can take it
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      res_push |-> buf_room)
      else $error("result beat pushed into a full buffer");

   // a non-final dump beat means the walk goes on, so no new item is taken
   a_dump_busy: assert property (@(posedge clock) disable iff (reset)
      (res_push && !res.last) |=> !req_tready)
      else $error("new item accepted in the middle of a dump");
`endif

endmodule

// ----- verif/bounded_double_ended_queue_tb.sv -----
// Self-checking testbench for the bounded double-ended queue: scoreboard class and stimulus.
module bounded_double_ended_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH          = 16;
   localparam int GAP_PCT        = 27;    // chance of an idle cycle on either side
   localparam int RANDOM_ITEMS   = 125;
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either channel

   // Shadow copy of the deque: ring of entries, front pointer and fill count.
   // Every accepted request is run through it and the beats it should cause
   // are queued; each response beat is matched against the oldest one.
   class deque_scoreboard;
      localparam int SLOTS = 16;

      logic [bdeq_pkg::VALUE_W-1:0] ring [SLOTS];
      logic [3:0]                   head;
      logic [bdeq_pkg::OCC_W-1:0]   held;
      bdeq_pkg::result_type         awaited [$];
      int                           failures;

      function new();
         head     = '0;
         held     = '0;
         failures = 0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      // occupancy is sampled after the state update
      function void queue_beat(logic [bdeq_pkg::VALUE_W-1:0] v, bdeq_pkg::stat_type st,
                               logic fin);
         bdeq_pkg::result_type r;
         r.entry_value = v;
         r.status      = st;
         r.last        = fin;
         r.occupancy   = held;
         awaited.push_back(r);
      endfunction

      function void note_request(bdeq_pkg::cmd_type cmd, logic [bdeq_pkg::VALUE_W-1:0] v);
         bdeq_pkg::stat_type st;
         logic [3:0]         idx;
         logic [4:0]         i;
         st = bdeq_pkg::STAT_OK;
         case (cmd)
            bdeq_pkg::CMD_PUSH_FRONT: begin
               if (held >= SLOTS) begin
                  st = bdeq_pkg::STAT_FULL;
               end else begin
                  head       = head - 4'd1;
                  ring[head] = v;
                  held++;
               end
            end
            bdeq_pkg::CMD_PUSH_BACK: begin
               if (held >= SLOTS) begin
                  st = bdeq_pkg::STAT_FULL;
               end else begin
                  idx       = head + held[3:0];
                  ring[idx] = v;
                  held++;
               end
            end
            bdeq_pkg::CMD_POP_FRONT: begin
               if (held == 0) begin
                  st = bdeq_pkg::STAT_EMPTY;
               end else begin
                  head = head + 4'd1;
                  held--;
               end
            end
            bdeq_pkg::CMD_POP_BACK: begin
               if (held == 0) st = bdeq_pkg::STAT_EMPTY;
               else held--;
            end
            bdeq_pkg::CMD_DUMP: begin
               // empty dump is a single beat flagged empty
               if (held == 0) begin
                  queue_beat('0, bdeq_pkg::STAT_EMPTY, 1'b1);
               end else begin
                  for (i = 0; i < held; i++) begin
                     idx = head + i[3:0];
                     queue_beat(ring[idx], bdeq_pkg::STAT_OK, i == held - 5'd1);
                  end
               end
               return;
            end
            default: ;  // unused codes: no change, plain ok beat
         endcase
         queue_beat('0, st, 1'b1);
      endfunction

      function void check_response(bdeq_pkg::result_type got);
         bdeq_pkg::result_type want;
         if (awaited.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected beat: value %h status %0d last %0b occ %0d",
                        got.entry_value, got.status, got.last, got.occupancy);
            return;
         end
         want = awaited.pop_front();
         if (got.entry_value != want.entry_value || got.status != want.status ||
             got.last != want.last || got.occupancy != want.occupancy) begin
            failures++;
            if (failures <= 10) begin
               $display("mismatch: exp value %h status %0d last %0b occ %0d",
                        want.entry_value, want.status, want.last, want.occupancy);
               $display("          got value %h status %0d last %0b occ %0d",
                        got.entry_value, got.status, got.last, got.occupancy);
            end
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic [2:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   deque_scoreboard sb;
   bit              no_gaps   = 1'b0;  // set for a stretch with both sides flat out
   int              quiet_run = 0;     // cycles since the last beat on either side

   bounded_double_ended_queue #(.DEPTH(DEPTH)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [31:0] value
      .req_tuser  (req_tuser),   // [2:0] command
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [31:0] entry_value, [36:32] occupancy, [39:37] zero
      .rsp_tuser  (rsp_tuser),   // [1:0] status
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver back-pressure, redrawn every cycle.
   always @(posedge clock)
      rsp_tready <= no_gaps || ($urandom_range(99) >= GAP_PCT);

   // Both monitors sample at the edge, before any of this edge's updates land.
   always @(posedge clock)
      if (!reset && req_tvalid && req_tready)
         sb.note_request(req_tuser, req_tdata);

   always @(posedge clock) begin
      bdeq_pkg::result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.entry_value = rsp_tdata[31:0];
         got.occupancy   = rsp_tdata[36:32];
         got.status      = rsp_tuser;
         got.last        = rsp_tlast;
         sb.check_response(got);
      end
   end

   // Watchdog: give up once neither channel has moved a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_run <= 0;
      else
         quiet_run <= quiet_run + 1;
      if (quiet_run >= WATCHDOG_LIMIT) begin
         $display("** bounded_double_ended_queue: FAILED **");
         $finish;
      end
   end

   // Mostly uniform, with the sign and all-ones/all-zeros corners drawn often.
   function automatic logic [31:0] random_value();
      case ($urandom_range(15))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return $urandom();
      endcase
   endfunction

   // One request beat; optional idle cycles first, then hold until accepted.
   task automatic send_item(input bdeq_pkg::cmd_type cmd, input logic [31:0] value);
      while (!no_gaps && $urandom_range(99) < GAP_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
   endtask

   // Hold off the sender until every queued beat has come back.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   initial begin
      int                n;
      int                pick;
      int                push_pct;
      bdeq_pkg::cmd_type cmd;

      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // --- directed: empty corners, unused codes, extremes, full corners ---
      send_item(bdeq_pkg::CMD_POP_FRONT, random_value());   // pop front of empty
      send_item(bdeq_pkg::CMD_POP_BACK, random_value());    // pop back of empty
      send_item(bdeq_pkg::CMD_DUMP, random_value());        // dump of empty
      for (n = 5; n < 8; n++)
         send_item(bdeq_pkg::cmd_type'(n), random_value()); // unused command codes
      send_item(bdeq_pkg::CMD_PUSH_FRONT, 32'h8000_0000);
      send_item(bdeq_pkg::CMD_PUSH_BACK, 32'h7fff_ffff);
      send_item(bdeq_pkg::CMD_POP_FRONT, random_value());
      send_item(bdeq_pkg::CMD_POP_BACK, random_value());
      // fill from both ends so the ring wraps below zero
      for (n = 0; n < DEPTH; n++)
         send_item(n[0] ? bdeq_pkg::CMD_PUSH_BACK : bdeq_pkg::CMD_PUSH_FRONT,
                   random_value());
      send_item(bdeq_pkg::CMD_PUSH_FRONT, random_value());  // full: dropped
      send_item(bdeq_pkg::CMD_PUSH_BACK, random_value());   // full: dropped
      send_item(bdeq_pkg::CMD_DUMP, random_value());        // longest dump

      // --- random: phases lean towards filling, draining or neither ---
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 40 || n == 115)
            wait_for_drain();
         no_gaps = (n >= 60 && n < 100);
         case ((n / 20) % 3)
            0:       push_pct = 75;
            1:       push_pct = 25;
            default: push_pct = 50;
         endcase
         pick = $urandom_range(99);
         if (pick < 4)
            cmd = bdeq_pkg::cmd_type'($urandom_range(7, 5));
         else if (pick < 14)
            cmd = bdeq_pkg::CMD_DUMP;
         else if ($urandom_range(99) < push_pct)
            cmd = $urandom_range(1) ? bdeq_pkg::CMD_PUSH_BACK : bdeq_pkg::CMD_PUSH_FRONT;
         else
            cmd = $urandom_range(1) ? bdeq_pkg::CMD_POP_BACK : bdeq_pkg::CMD_POP_FRONT;
         send_item(cmd, random_value());
      end
      no_gaps = 1'b0;

      // drain, then keep waiting for stray beats before the verdict
      wait_for_drain();
      repeat (2 * DEPTH + 4) @(posedge clock);

      if (sb.failures == 0 && sb.pending() == 0)
         $display("** bounded_double_ended_queue: PASSED **");
      else
         $display("** bounded_double_ended_queue: FAILED **");
      $finish;
   end

endmodule
